// File: rtl/aflc_pkg.sv
package aflc_pkg;

	localparam int WAYS  = 4;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W = $clog2(WAYS + 1);

	localparam int KEY_W   = 16;
	localparam int VALUE_W = 16;
	localparam int STAMP_W = 32;
	localparam int HITS_W  = 32;

	localparam int ADDR_W = 3;
	localparam logic REG_POLICY = 1'b0;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [WAY_W-1:0]   idx;
	} best_t;

	typedef struct packed {
		logic entry_en;
		logic stamp_en;
	} cell_wr_t;

endpackage

// File: rtl/assoc_cache_fifo_lru.sv
// Small fully associative cache built as a row of way cells.
// Input stream s_axis: each transaction carries a lookup key and the
// backing-store value for that key. Output stream m_axis: one transaction per
// request with the key, the returned value, the running hit count and a hit
// flag in tuser. The APB port holds one register, the replacement policy
// (0 round robin, 1 least recently used); the user must write it only while
// the block idles, as the block itself does not enforce this. A request is
// registered on acceptance, then the tag compare runs in parallel in every
// cell, and the result goes to the output register. A miss with all ways full
// under LRU adds a scan state, the time the oldest stamp needs to ripple
// through the row of cells. Requests are accepted only in the idle state, so a
// new one waits for the last to commit; a full LRU miss holds it off longer.
// A new request is accepted while the previous result still waits in the
// output register; if the receiver stalls, the next request holds before
// its commit until the output register is free, and the input then stalls.
// Reset empties the cache, clears the hit count and the stamp clock, and
// selects round robin replacement. No clearing pass is needed.
module assoc_cache_fifo_lru (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// lookup_key [15:0], backing_value [31:16]
	input  logic [31:0]                  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// out_key [15:0], out_value [31:16], hit_total [63:32]
	output logic [63:0]                  m_axis_tdata,
	// was_hit [0]
	output logic                         m_axis_tuser,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aflc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import aflc_pkg::*;

	state_t state_q, state_next;

	logic                policy_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  val_q;
	logic [CNT_W-1:0]    filled_q;
	logic [WAY_W-1:0]    fifo_ptr_q;
	logic [STAMP_W-1:0]  use_clock_q;
	logic [HITS_W-1:0]   hit_cnt_q;
	logic [WAY_W-1:0]    scan_cnt_q;

	logic                out_valid_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic                out_hit_q;
	logic [HITS_W-1:0]   out_hits_q;

	logic [WAYS-1:0]     match_vec;
	logic [WAYS-1:0]     filled_vec;
	logic [VALUE_W-1:0]  value_vec [WAYS];
	best_t               best_vec [WAYS];
	cell_wr_t            wr_vec [WAYS];

	logic                accept;
	logic                cfg_wr;
	logic                out_free;
	logic                hit;
	logic [WAY_W-1:0]    hit_way;
	logic                full;
	logic                need_scan;
	logic                commit;
	logic [WAY_W-1:0]    target;
	logic [VALUE_W-1:0]  result_value;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign full     = (filled_q == CNT_W'(WAYS));

	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_POLICY) begin
			prdata = {31'd0, policy_q};
		end
	end

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
		end
	end

	assign need_scan = !hit && full && (policy_q == POLICY_LRU);

	always_comb begin
		if (hit) begin
			target = hit_way;
		end else if (!full) begin
			target = filled_q[WAY_W-1:0];
		end else if (policy_q == POLICY_LRU) begin
			target = best_vec[WAYS-1].idx;
		end else begin
			target = fifo_ptr_q;
		end
	end

	assign result_value = hit ? value_vec[hit_way] : val_q;

	always_comb begin
		state_next    = state_q;
		commit        = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_next = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (need_scan) begin
					state_next = ST_SCAN;
				end else if (out_free) begin
					commit     = 1'b1;
					state_next = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == WAY_W'(WAYS - 1) && out_free) begin
					commit     = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POLICY_FIFO;
			filled_q    <= '0;
			fifo_ptr_q  <= '0;
			use_clock_q <= '0;
			hit_cnt_q   <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr[2] == REG_POLICY) begin
				policy_q <= pwdata[0];
			end
			if (state_q == ST_SCAN) begin
				if (scan_cnt_q != WAY_W'(WAYS - 1)) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
			end else begin
				scan_cnt_q <= '0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (hit) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end
				if (!hit || policy_q == POLICY_LRU) begin
					use_clock_q <= use_clock_q + 1'b1;
				end
				if (!hit && !full) begin
					filled_q <= filled_q + 1'b1;
				end
				if (!hit && full && policy_q == POLICY_FIFO) begin
					if (fifo_ptr_q == WAY_W'(WAYS - 1)) begin
						fifo_ptr_q <= '0;
					end else begin
						fifo_ptr_q <= fifo_ptr_q + 1'b1;
					end
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= s_axis_tdata[15:0];
			val_q <= s_axis_tdata[31:16];
		end
		if (commit) begin
			out_key_q   <= key_q;
			out_value_q <= result_value;
			out_hit_q   <= hit;
			out_hits_q  <= hit ? hit_cnt_q + 1'b1 : hit_cnt_q;
		end
	end

	for (genvar i = 0; i < WAYS; i++) begin : g_way
		best_t best_in;

		assign filled_vec[i] = (CNT_W'(i) < filled_q);
		assign wr_vec[i].entry_en = commit && !hit && (target == WAY_W'(i));
		assign wr_vec[i].stamp_en = commit && (target == WAY_W'(i))
			&& (!hit || policy_q == POLICY_LRU);

		if (i == 0) begin : g_head
			assign best_in = '{stamp: '1, idx: '0};
		end else begin : g_link
			assign best_in = best_vec[i-1];
		end

		aflc_cell u_cell (
			.clk      (clk),
			.index    (WAY_W'(i)),
			.filled   (filled_vec[i]),
			.key      (key_q),
			.wr       (wr_vec[i]),
			.wr_tag   (key_q),
			.wr_value (val_q),
			.wr_stamp (use_clock_q),
			.best_in  (best_in),
			.match    (match_vec[i]),
			.value    (value_vec[i]),
			.best_out (best_vec[i])
		);
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_hits_q, out_value_q, out_key_q};
	assign m_axis_tuser  = out_hit_q;

	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= CNT_W'(WAYS))
		else $error("fill count exceeds the number of ways");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_ptr_q <= WAY_W'(WAYS - 1))
		else $error("round robin pointer out of range");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOKUP |-> $onehot0(match_vec))
		else $error("key held in more than one way");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit && hit |=> hit_cnt_q == $past(hit_cnt_q) + 1'b1)
		else $error("hit count did not advance on a hit");

	a_ptr_still: assert property (@(posedge clk) disable iff (!arst_n)
		!full |=> $stable(fifo_ptr_q))
		else $error("round robin pointer moved while free ways remain");

endmodule

// File: rtl/aflc_cell.sv
module aflc_cell (
	input  logic                           clk,
	input  logic [aflc_pkg::WAY_W-1:0]     index,
	input  logic                           filled,
	input  logic [aflc_pkg::KEY_W-1:0]     key,
	input  aflc_pkg::cell_wr_t             wr,
	input  logic [aflc_pkg::KEY_W-1:0]     wr_tag,
	input  logic [aflc_pkg::VALUE_W-1:0]   wr_value,
	input  logic [aflc_pkg::STAMP_W-1:0]   wr_stamp,
	input  aflc_pkg::best_t                best_in,
	output logic                           match,
	output logic [aflc_pkg::VALUE_W-1:0]   value,
	output aflc_pkg::best_t                best_out
);
	import aflc_pkg::*;

	logic [KEY_W-1:0]   tag_q;
	logic [VALUE_W-1:0] value_q;
	logic [STAMP_W-1:0] stamp_q;
	best_t              best_q;

	always_ff @(posedge clk) begin
		if (wr.entry_en) begin
			tag_q   <= wr_tag;
			value_q <= wr_value;
		end
		if (wr.stamp_en) begin
			stamp_q <= wr_stamp;
		end
		// The oldest stamp seen so far moves one cell down the row each cycle.
		if (stamp_q < best_in.stamp) begin
			best_q <= '{stamp: stamp_q, idx: index};
		end else begin
			best_q <= best_in;
		end
	end

	assign match    = filled && (tag_q == key);
	assign value    = value_q;
	assign best_out = best_q;

endmodule

// File: tb/assoc_cache_fifo_lru_check.sv
`timescale 1ns / 1ps

module assoc_cache_fifo_lru_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	// lookup_key [15:0], backing_value [31:16]
	input  logic [31:0]                   s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_key [15:0], out_value [31:16], hit_total [63:32]
	input  logic [63:0]                   m_axis_tdata,
	// was_hit [0]
	input  logic                          m_axis_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aflc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	output int                            mismatches,
	output int                            backlog,
	output int                            hits_seen,
	output int                            misses_seen
);
	import aflc_pkg::*;

	localparam logic [ADDR_W-1:0] POLICY_ADDR = ADDR_W'(4 * REG_POLICY);

	typedef struct {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic               hit;
		logic [HITS_W-1:0]  hits;
	} reply_t;

	logic [KEY_W-1:0]   tags [WAYS];
	logic [VALUE_W-1:0] values [WAYS];
	logic [STAMP_W-1:0] stamps [WAYS];
	int                 filled;
	int                 fifo_ptr;
	logic [STAMP_W-1:0] use_clock;
	logic [HITS_W-1:0]  hit_count;
	logic               policy;

	reply_t replies [$];
	reply_t want;
	reply_t got;
	int     reply_no;

	initial begin
		mismatches  = 0;
		backlog     = 0;
		hits_seen   = 0;
		misses_seen = 0;
	end

	task automatic predict_lookup(input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] bval,
			output reply_t r);
		int hw;
		int w;
		int victim;
		hw = -1;
		for (w = 0; w < filled; w++) begin
			if (hw < 0 && tags[w] == key) begin
				hw = w;
			end
		end
		if (hw >= 0) begin
			hit_count = hit_count + 1'b1;
			r.value = values[hw];
			if (policy == POLICY_LRU) begin
				stamps[hw] = use_clock;
				use_clock = use_clock + 1'b1;
			end
		end else begin
			if (filled < WAYS) begin
				victim = filled;
				filled++;
			end else if (policy == POLICY_FIFO) begin
				victim = fifo_ptr;
				fifo_ptr = (fifo_ptr + 1) % WAYS;
			end else begin
				victim = 0;
				for (w = 1; w < WAYS; w++) begin
					if (stamps[w] < stamps[victim]) begin
						victim = w;
					end
				end
			end
			tags[victim]   = key;
			values[victim] = bval;
			stamps[victim] = use_clock;
			use_clock = use_clock + 1'b1;
			r.value = bval;
		end
		r.key  = key;
		r.hit  = (hw >= 0);
		r.hits = hit_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled    = 0;
			fifo_ptr  = 0;
			use_clock = '0;
			hit_count = '0;
			policy    = POLICY_FIFO;
			reply_no  = 0;
			replies.delete();
			backlog = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.key   = m_axis_tdata[15:0];
				got.value = m_axis_tdata[31:16];
				got.hits  = m_axis_tdata[63:32];
				got.hit   = m_axis_tuser;
				if (got.hit) begin
					hits_seen++;
				end else begin
					misses_seen++;
				end
				if (replies.size() == 0) begin
					if (mismatches < 10) begin
						$display("Unexpected result: key %h value %h hit %b hits %0d",
							got.key, got.value, got.hit, got.hits);
					end
					mismatches++;
				end else begin
					want = replies.pop_front();
					if (got.key !== want.key || got.value !== want.value ||
							got.hit !== want.hit || got.hits !== want.hits) begin
						if (mismatches < 10) begin
							$display("Mismatch on result %0d: expected key %h value %h hit %b hits %0d",
								reply_no, want.key, want.value, want.hit, want.hits);
							$display("    got key %h value %h hit %b hits %0d",
								got.key, got.value, got.hit, got.hits);
						end
						mismatches++;
					end
				end
				reply_no++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_lookup(s_axis_tdata[15:0], s_axis_tdata[31:16], want);
				replies.push_back(want);
			end
			if (psel && penable && pwrite && pready && paddr == POLICY_ADDR) begin
				policy = pwdata[0];
			end
			backlog = replies.size();
		end
	end

endmodule

// File: tb/assoc_cache_fifo_lru_test.sv
`timescale 1ns / 1ps

module assoc_cache_fifo_lru_test;
	import aflc_pkg::*;

	localparam logic [ADDR_W-1:0] POLICY_ADDR = ADDR_W'(4 * REG_POLICY);
	localparam logic [ADDR_W-1:0] SPARE_ADDR  = ADDR_W'(4 * (REG_POLICY + 1));
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 238;
	localparam int QUIET_LIMIT = 2000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [63:0]         m_axis_tdata;
	logic                m_axis_tuser;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	int mismatches;
	int backlog;
	int hits_seen;
	int misses_seen;

	logic calm = 1'b1;
	int   stall_left = 0;
	int   quiet = 0;
	int   requests = 0;
	int   reg_writes = 0;

	logic [KEY_W-1:0] key_pool [WAYS + 3];
	int               pool_size;
	int               phase;
	int               n;
	logic [KEY_W-1:0] key;

	assoc_cache_fifo_lru i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	assoc_cache_fifo_lru_check i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.backlog       (backlog),
		.hits_seen     (hits_seen),
		.misses_seen   (misses_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] phase_wdata(int p);
		case (p)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_0001;
			3: return 32'hFFFF_FFFE;
			4: return 32'h8000_0001;
			default: return 32'h0000_0000;
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			stall_left = idle_span() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, backlog);
				$display("** assoc_cache_fifo_lru: FAILED **");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic send_request(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
		int  gap;
		logic taken;
		gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_span();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {v, k};
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		requests++;
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		logic done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do begin
			@(negedge clk);
		end while (backlog != 0);
		repeat (2 * WAYS + 4) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b1;
		send_request(16'h0000, 16'hFFFF);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'h0000, 16'h1234);
		send_request(16'h0001, 16'hAAAA);
		send_request(16'h0002, 16'h5555);
		send_request(16'h0003, 16'h0000);
		send_request(16'h0000, 16'h0001);
		send_request(16'h0002, 16'hFFFF);
		send_request(16'hFFFF, 16'hFFFF);
		drain();

		reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
		reg_write(POLICY_ADDR, 32'h0000_0001);
		send_request(16'h0002, 16'h0000);
		send_request(16'h0000, 16'h0000);
		send_request(16'h0007, 16'h7777);
		send_request(16'h0003, 16'h3333);
		send_request(16'h0008, 16'h8888);
		send_request(16'h0002, 16'h2222);
		send_request(16'h0009, 16'h9999);
		send_request(16'h0000, 16'hFFFF);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'h0007, 16'h0101);
		send_request(16'h000A, 16'hAAAA);
		send_request(16'h0008, 16'h0000);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			reg_write(POLICY_ADDR, phase_wdata(phase));
			calm = (phase == 2);
			pool_size = $urandom_range(2, WAYS + 3);
			for (n = 0; n < WAYS + 3; n++) begin
				key_pool[n] = KEY_W'($urandom());
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					key = key_pool[$urandom_range(0, pool_size - 1)];
				end else begin
					key = KEY_W'($urandom());
				end
				send_request(key, VALUE_W'($urandom()));
			end
		end
		drain();

		$display("Covered %0d requests (%0d hits, %0d misses) with %0d register writes,",
			requests, hits_seen, misses_seen, reg_writes);
		$display("switching between round-robin and least-recently-used replacement.");
		if (mismatches == 0 && backlog == 0) begin
			$display("** assoc_cache_fifo_lru: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, backlog);
			$display("** assoc_cache_fifo_lru: FAILED **");
		end
		$finish;
	end

endmodule

// File: assoc_cache_fifo_lru.f
rtl/aflc_pkg.sv
rtl/aflc_cell.sv
rtl/assoc_cache_fifo_lru.sv
tb/assoc_cache_fifo_lru_check.sv
tb/assoc_cache_fifo_lru_test.sv
